@@ hw/rtl/wbpu_pkg.sv @@
// Package for the winner bonus probability table.
// Field widths, fixed-point constants, operation and register codes, channel words.
// No dependencies.
package wbpu_pkg;

    localparam int PROB_FRAC_BITS  = 16;
    localparam int PROB_W          = PROB_FRAC_BITS + 1;
    localparam int SUM_W           = PROB_W + 1;
    localparam int INDEX_W         = 3;
    localparam int ACTIVE_W        = 4;
    localparam int MAX_ENTRIES_DEF = 8;
    localparam int BIT_W           = $clog2(PROB_W);

    localparam logic [PROB_W-1:0] PROB_ONE = PROB_W'(1) << PROB_FRAC_BITS;
    localparam logic [BIT_W-1:0]  BIT_LAST = BIT_W'(PROB_W - 1);
    localparam logic [ACTIVE_W-1:0] ACTIVE_RST = ACTIVE_W'(8);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BONUS = 2'd2
    } t_op;

    typedef enum logic [0:0] {
        CFG_BONUS_FACTOR = 1'b0,
        CFG_ACTIVE_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]         op;
        logic [INDEX_W-1:0] entry_index;
        logic [PROB_W-1:0]  prob_value;
    } t_in_word;

    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic [PROB_W-1:0]  out_prob;
        logic               last;
        logic               winner_saturated;
    } t_out_word;

    typedef struct packed {
        logic [0:0]        reg_index;
        logic [PROB_W-1:0] wdata;
    } t_cfg_word;

endpackage

@@ hw/rtl/wbpu_stream_if.sv @@
// Valid/ready channel carrying one word of type T.
// Word types come from wbpu_pkg.
interface wbpu_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/winner_bonus_probability_update.sv @@
// Winner bonus probability table: top level, sequencer, shared adder and table memory.
// Depends on wbpu_pkg and wbpu_stream_if.
//
//   channel | dir | word        | notes
//   i_in    | in  | t_in_word   | write / read / bonus item
//   o_out   | out | t_out_word  | one word per reported entry, last on final
//   i_cfg   | in  | t_cfg_word  | bonus_factor, active_count; always ready
//
// Write: stored as the item is accepted in idle. Read: table read in idle, then output.
// Bonus: the 17-step shift-add multiply and the 17-step restoring divide both
// run on the one 18-bit adder.
// Reset: per-entry valid bits clear at once, so the table reads as zero; no sweep.
// i_in is ready only in idle; a full output register holds the sequencer until taken.
module winner_bonus_probability_update #(
    parameter int MAX_ENTRIES = wbpu_pkg::MAX_ENTRIES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wbpu_stream_if.sink   i_in,
    wbpu_stream_if.source o_out,
    wbpu_stream_if.sink   i_cfg
);

    localparam int PW = wbpu_pkg::PROB_W;
    localparam int AW = wbpu_pkg::SUM_W;
    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int BW = wbpu_pkg::BIT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_PW,
        S_MUL,
        S_SATCHK,
        S_SAT_WR,
        S_DIV,
        S_WALK_RD,
        S_WALK_CMP,
        S_WALK_PEN,
        S_WIN_SUB,
        S_WIN_ADD,
        S_EMIT_RD,
        S_PUT
    } t_state;

    t_state r_state;

    // configuration
    logic [PW-1:0]                 r_bonus_factor;
    logic [wbpu_pkg::ACTIVE_W-1:0] r_active_count;

    // datapath registers
    logic [IW-1:0] r_w;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_pw;
    logic [PW-1:0] r_acc;
    logic [PW-1:0] r_lo;
    logic [PW-1:0] r_bonus;
    logic [PW-1:0] r_step;
    logic [PW-1:0] r_rem;
    logic [PW-1:0] r_pen;
    logic [PW-1:0] r_cur;
    logic [BW-1:0] r_bit;
    logic          r_sat;
    logic          r_is_read;
    logic          r_rd_oob;
    logic [wbpu_pkg::INDEX_W-1:0] r_idx;

    logic                  r_out_valid;
    wbpu_pkg::t_out_word   r_out;

    // table memory
    logic [PW-1:0]          r_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [PW-1:0]          r_rdata;
    logic                   r_rd_ok;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] wr_addr;
    logic [PW-1:0] wr_data;
    logic [PW-1:0] rd_val;

    // shared adder
    logic [AW-1:0] alu_a;
    logic [AW-1:0] alu_b;
    logic          alu_sub;
    logic [AW:0]   alu_res;
    logic          alu_ge;
    logic [PW-1:0] alu_low;

    logic          in_acc;
    logic          in_in_tbl;
    logic [CW-1:0] act_n;
    logic [PW-1:0] bf_eff;
    logic [PW-1:0] bonus_w;
    logic [PW-1:0] clamp_val;
    logic [AW-1:0] rem_sh;
    logic          walk_end;
    logic          out_free;
    logic          put_last;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign in_in_tbl = 32'(i_in.data.entry_index) < MAX_ENTRIES;
    assign bf_eff    = (r_bonus_factor > wbpu_pkg::PROB_ONE) ? wbpu_pkg::PROB_ONE
                                                             : r_bonus_factor;
    assign clamp_val = (i_in.data.prob_value > wbpu_pkg::PROB_ONE) ? wbpu_pkg::PROB_ONE
                                                                    : i_in.data.prob_value;
    // product >> frac: high half plus top bit of the low half
    assign bonus_w   = PW'({r_acc, r_lo[PW-1]});
    assign rem_sh    = {r_rem, r_step[PW-1]};
    assign rd_val    = r_rd_ok ? r_rdata : '0;
    assign walk_end  = (r_cnt == r_n - CW'(1));
    assign out_free  = !r_out_valid || o_out.ready;
    assign put_last  = r_is_read || walk_end;

    always_comb begin
        if (r_active_count == '0) begin
            act_n = CW'(1);
        end else if (32'(r_active_count) > MAX_ENTRIES) begin
            act_n = CW'(MAX_ENTRIES);
        end else begin
            act_n = CW'(r_active_count);
        end
    end

    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
    assign alu_ge  = alu_res[AW];
    assign alu_low = alu_res[PW-1:0];

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_MUL: begin
                alu_a = AW'(r_acc);
                alu_b = r_lo[0] ? AW'(r_pw) : '0;
            end
            S_SATCHK: begin
                alu_a = AW'(r_pw);
                alu_b = AW'(bonus_w);
            end
            S_DIV: begin
                alu_a   = rem_sh;
                alu_b   = AW'(r_n - CW'(1));
                alu_sub = 1'b1;
            end
            S_WALK_CMP: begin
                alu_a   = AW'(rd_val);
                alu_b   = AW'(r_step);
                alu_sub = 1'b1;
            end
            S_WALK_PEN: begin
                alu_a = AW'(r_pen);
                alu_b = AW'(r_cur);
            end
            S_WIN_SUB: begin
                alu_a   = AW'(r_bonus);
                alu_b   = AW'(r_pen);
                alu_sub = 1'b1;
            end
            S_WIN_ADD: begin
                alu_a = AW'(r_pw);
                alu_b = AW'(r_cur);
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = IW'(r_cnt);
        mem_we  = 1'b0;
        wr_addr = IW'(r_cnt);
        wr_data = '0;
        unique case (r_state)
            S_IDLE: begin
                rd_en   = 1'b1;
                rd_addr = IW'(i_in.data.entry_index);
                wr_addr = IW'(i_in.data.entry_index);
                wr_data = clamp_val;
                mem_we  = in_acc && (i_in.data.op == wbpu_pkg::OP_WRITE) && in_in_tbl;
            end
            S_SAT_WR: begin
                mem_we  = 1'b1;
                wr_data = (IW'(r_cnt) == r_w) ? wbpu_pkg::PROB_ONE : '0;
            end
            S_WALK_RD, S_EMIT_RD: begin
                rd_en = 1'b1;
            end
            S_WALK_CMP: begin
                mem_we  = 1'b1;
                wr_data = alu_ge ? alu_low : '0;
            end
            S_WIN_ADD: begin
                mem_we  = 1'b1;
                wr_addr = r_w;
                wr_data = alu_low;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_out_valid    <= 1'b0;
            r_bonus_factor <= '0;
            r_active_count <= wbpu_pkg::ACTIVE_RST;
            r_is_read      <= 1'b0;
            r_sat          <= 1'b0;
            r_cnt          <= '0;
            r_bit          <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (wbpu_pkg::t_cfg_reg'(i_cfg.data.reg_index))
                    wbpu_pkg::CFG_BONUS_FACTOR: r_bonus_factor <= i_cfg.data.wdata;
                    wbpu_pkg::CFG_ACTIVE_COUNT:
                        r_active_count <= i_cfg.data.wdata[wbpu_pkg::ACTIVE_W-1:0];
                    default: r_bonus_factor <= r_bonus_factor;
                endcase
            end

            // in S_PUT the output register is refilled whenever it is free
            if (r_out_valid && o_out.ready && (r_state != S_PUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_idx     <= i_in.data.entry_index;
                        r_rd_oob  <= !in_in_tbl;
                        r_cnt     <= '0;
                        r_sat     <= 1'b0;
                        r_is_read <= 1'b0;
                        r_n       <= act_n;
                        r_w       <= IW'(i_in.data.entry_index);
                        if (i_in.data.op == wbpu_pkg::OP_READ) begin
                            r_is_read <= 1'b1;
                            r_state   <= S_PUT;
                        end else if (i_in.data.op == wbpu_pkg::OP_BONUS) begin
                            if (32'(i_in.data.entry_index) < 32'(act_n)) begin
                                r_state <= S_LOAD_PW;
                            end else begin
                                r_state <= S_EMIT_RD;
                            end
                        end
                    end
                end
                S_LOAD_PW: begin
                    r_pw    <= rd_val;
                    r_acc   <= '0;
                    r_lo    <= bf_eff;
                    r_bit   <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // shift-add, LSB of multiplier first
                    r_acc <= alu_res[PW:1];
                    r_lo  <= {alu_res[0], r_lo[PW-1:1]};
                    r_bit <= r_bit + BW'(1);
                    if (r_bit == wbpu_pkg::BIT_LAST) begin
                        r_state <= S_SATCHK;
                    end
                end
                S_SATCHK: begin
                    r_bonus <= bonus_w;
                    r_pen   <= '0;
                    r_cnt   <= '0;
                    if (alu_res[AW-1:0] >= AW'(wbpu_pkg::PROB_ONE)) begin
                        r_sat   <= 1'b1;
                        r_state <= S_SAT_WR;
                    end else if (r_n == CW'(1)) begin
                        r_state <= S_WIN_SUB;
                    end else begin
                        r_step  <= bonus_w;
                        r_rem   <= '0;
                        r_bit   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_SAT_WR: begin
                    if (walk_end) begin
                        r_cnt   <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DIV: begin
                    // restoring divide; quotient bits shift in behind the dividend
                    r_rem  <= alu_ge ? alu_low : rem_sh[PW-1:0];
                    r_step <= {r_step[PW-2:0], alu_ge};
                    r_bit  <= r_bit + BW'(1);
                    if (r_bit == wbpu_pkg::BIT_LAST) begin
                        r_state <= S_WALK_RD;
                    end
                end
                S_WALK_RD: begin
                    if (IW'(r_cnt) == r_w) begin
                        if (walk_end) begin
                            r_state <= S_WIN_SUB;
                        end else begin
                            r_cnt <= r_cnt + CW'(1);
                        end
                    end else begin
                        r_state <= S_WALK_CMP;
                    end
                end
                S_WALK_CMP: begin
                    if (!alu_ge) begin
                        r_cur   <= rd_val;
                        r_state <= S_WALK_PEN;
                    end else if (walk_end) begin
                        r_state <= S_WIN_SUB;
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_WALK_RD;
                    end
                end
                S_WALK_PEN: begin
                    r_pen <= alu_low;
                    if (walk_end) begin
                        r_state <= S_WIN_SUB;
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_WALK_RD;
                    end
                end
                S_WIN_SUB: begin
                    r_cnt <= '0;
                    // winner gains only if the penalty stays below the bonus
                    if (alu_ge && (alu_low != '0)) begin
                        r_cur   <= alu_low;
                        r_state <= S_WIN_ADD;
                    end else begin
                        r_state <= S_EMIT_RD;
                    end
                end
                S_WIN_ADD: begin
                    r_state <= S_EMIT_RD;
                end
                S_EMIT_RD: begin
                    r_state <= S_PUT;
                end
                S_PUT: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out.out_index            <= r_is_read ? r_idx
                                                                : wbpu_pkg::INDEX_W'(r_cnt);
                        r_out.out_prob             <= (r_is_read && r_rd_oob) ? '0 : rd_val;
                        r_out.last                 <= put_last;
                        r_out.winner_saturated     <= r_sat;
                        if (put_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
